// ===== src/ofdwq_pkg.sv =====
// Shared types and constants for the oldest-first dirty write-back queue.
package ofdwq_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_FLUSHED   = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // What a slot cell does on the next clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_SHIFT = 3'd1,  // take the right neighbor's entry
        CELL_WRAP  = 3'd2,  // take the head entry (tail of the rotating ring)
        CELL_WRITE = 3'd3,  // load a new entry
        CELL_TOUCH = 3'd4   // refresh timestamp only
    } cell_cmd_t;

    typedef struct packed {
        logic [7:0]  position;
        logic [31:0] stamp;
    } slot_t;

endpackage

// ===== src/oldest_first_dirty_writeback_queue_core.sv =====
// Top level: slot row, request sequencer and result register.
// Mark: the request moves to S_MARK, which loads the result register once it is free, then returns to idle.
// Flush: each removed entry is found as the row rotates once through the head cell (S_FSTART,
// S_SCAN, S_REMOVE); close-out in S_FEND at the count limit, on an empty table or if a search finds none.
// A new input is taken in the idle state, also while a result waits in the output register.
// Reset (rst_n low, async) empties the table and the result register; slot contents
// are not cleared and are never read before being written.
module oldest_first_dirty_writeback_queue_core #(
    parameter int TABLE_DEPTH = ofdwq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          position,
    input  logic [31:0]         now_ms,
    input  logic [5:0]          max_count,
    input  logic [31:0]         min_age_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output ofdwq_pkg::status_t  status,
    output logic [7:0]          entry_position,
    output logic [5:0]          entries_left,
    output logic                last
);
    import ofdwq_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MARK   = 6'b000010,
        S_FSTART = 6'b000100,
        S_SCAN   = 6'b001000,
        S_REMOVE = 6'b010000,
        S_FEND   = 6'b100000
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   emitted_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [31:0]        best_time_reg;
    logic [7:0]         best_pos_reg;
    logic               found_reg;

    logic [7:0]         req_pos_reg;
    logic [31:0]        now_reg;
    logic [5:0]         maxc_reg;
    logic [31:0]        min_age_reg;

    logic               have_pend_reg;
    logic [7:0]         pend_pos_reg;
    logic [CNT_W-1:0]   pend_left_reg;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [7:0]         out_pos_reg;
    logic [CNT_W-1:0]   out_left_reg;
    logic               last_reg;

    slot_t              slots [TABLE_DEPTH];
    cell_cmd_t          cmds  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match;
    logic               any_match;
    logic               out_free;
    logic               can_move;
    logic               out_load;
    logic               scan_end;
    logic [31:0]        age;
    logic               elig;
    logic               take;
    slot_t              wr_slot;

    assign out_free  = !out_valid_reg || out_ready;
    assign can_move  = !have_pend_reg || out_free;
    assign any_match = |match;
    assign scan_end  = (scan_idx_reg == IDX_W'(count_reg - CNT_W'(1)));
    assign out_load  = ((state_reg == S_MARK) && out_free) ||
                       ((state_reg == S_REMOVE) && can_move && have_pend_reg) ||
                       ((state_reg == S_FEND) && out_free);

    // head of the row is examined while the row rotates
    assign age  = now_reg - slots[0].stamp;
    assign elig = (min_age_reg == 32'd0) || (age >= min_age_reg);
    assign take = elig && (!found_reg || (slots[0].stamp < best_time_reg));

    assign wr_slot.position = req_pos_reg;
    assign wr_slot.stamp    = now_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            slot_t nb_slot;
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign nb_slot = '0;
            end
            else
            begin : g_mid
                assign nb_slot = slots[gi + 1];
            end

            assign match[gi] = (CNT_W'(gi) < count_reg) &&
                               (slots[gi].position == req_pos_reg);

            always_comb
            begin
                cmds[gi] = CELL_HOLD;
                case (state_reg)
                    S_MARK:
                    begin
                        if (out_free)
                        begin
                            if (match[gi])
                                cmds[gi] = CELL_TOUCH;
                            else if (!any_match && (CNT_W'(gi) == count_reg))
                                cmds[gi] = CELL_WRITE;
                        end
                    end
                    S_SCAN:
                    begin
                        if (CNT_W'(gi + 1) < count_reg)
                            cmds[gi] = CELL_SHIFT;
                        else if (CNT_W'(gi + 1) == count_reg)
                            cmds[gi] = CELL_WRAP;
                    end
                    S_REMOVE:
                    begin
                        if (can_move && (IDX_W'(gi) >= best_idx_reg) &&
                            (CNT_W'(gi + 1) < count_reg))
                            cmds[gi] = CELL_SHIFT;
                    end
                    default: cmds[gi] = CELL_HOLD;
                endcase
            end

            ofdwq_cell u_cell (
                .clk  (clk),
                .cmd  (cmds[gi]),
                .nb   (nb_slot),
                .head (slots[0]),
                .wr   (wr_slot),
                .slot (slots[gi])
            );
        end
    endgenerate

    // request fields and search payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_pos_reg  <= position;
            now_reg      <= now_ms;
            maxc_reg     <= max_count;
            min_age_reg  <= min_age_ms;
        end
        if (state_reg == S_SCAN && take)
        begin
            best_idx_reg  <= scan_idx_reg;
            best_time_reg <= slots[0].stamp;
            best_pos_reg  <= slots[0].position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            emitted_reg   <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            have_pend_reg <= 1'b0;
            pend_pos_reg  <= '0;
            pend_left_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_NONE;
            out_pos_reg   <= '0;
            out_left_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        emitted_reg   <= '0;
                        have_pend_reg <= 1'b0;
                        state_reg     <= req_type ? S_FSTART : S_MARK;
                    end
                end
                S_MARK:
                begin
                    if (out_free)
                    begin
                        out_pos_reg   <= req_pos_reg;
                        last_reg      <= 1'b1;
                        if (any_match)
                        begin
                            status_reg   <= ST_REFRESHED;
                            out_left_reg <= count_reg;
                        end
                        else if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            status_reg   <= ST_ADDED;
                            out_left_reg <= count_reg + CNT_W'(1);
                            count_reg    <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_reg   <= ST_DROPPED;
                            out_left_reg <= count_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_FSTART:
                begin
                    if ((32'(emitted_reg) == 32'(maxc_reg)) || (count_reg == '0))
                        state_reg <= S_FEND;
                    else
                    begin
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (take)
                        found_reg <= 1'b1;
                    if (scan_end)
                        state_reg <= (found_reg || take) ? S_REMOVE : S_FEND;
                    else
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                S_REMOVE:
                begin
                    if (can_move)
                    begin
                        // previous flushed entry is not the final one
                        if (have_pend_reg)
                        begin
                            status_reg    <= ST_FLUSHED;
                            out_pos_reg   <= pend_pos_reg;
                            out_left_reg  <= pend_left_reg;
                            last_reg      <= 1'b0;
                        end
                        have_pend_reg <= 1'b1;
                        pend_pos_reg  <= best_pos_reg;
                        pend_left_reg <= count_reg - CNT_W'(1);
                        count_reg     <= count_reg - CNT_W'(1);
                        emitted_reg   <= emitted_reg + CNT_W'(1);
                        state_reg     <= S_FSTART;
                    end
                end
                S_FEND:
                begin
                    if (out_free)
                    begin
                        last_reg      <= 1'b1;
                        if (have_pend_reg)
                        begin
                            status_reg   <= ST_FLUSHED;
                            out_pos_reg  <= pend_pos_reg;
                            out_left_reg <= pend_left_reg;
                        end
                        else
                        begin
                            status_reg   <= ST_NONE;
                            out_pos_reg  <= '0;
                            out_left_reg <= count_reg;
                        end
                        have_pend_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_position = out_pos_reg;
    assign entries_left   = 6'(out_left_reg);
    assign last           = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("search running on an empty table");

    a_pend_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        have_pend_reg |-> ((state_reg == S_FSTART) || (state_reg == S_SCAN) ||
                           (state_reg == S_REMOVE) || (state_reg == S_FEND)))
        else $error("held flush result outside a flush");

    a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE && can_move) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not drop exactly one entry");

    a_mark_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |=> (count_reg >= $past(count_reg)))
        else $error("mark request shrank the table");

endmodule

// ===== src/ofdwq_cell.sv =====
// One table slot: holds a position and a timestamp, moves data along the row.
module ofdwq_cell (
    input  logic                  clk,
    input  ofdwq_pkg::cell_cmd_t  cmd,
    input  ofdwq_pkg::slot_t      nb,
    input  ofdwq_pkg::slot_t      head,
    input  ofdwq_pkg::slot_t      wr,
    output ofdwq_pkg::slot_t      slot
);
    import ofdwq_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        case (cmd)
            CELL_HOLD:  slot_next = slot_reg;
            CELL_SHIFT: slot_next = nb;
            CELL_WRAP:  slot_next = head;
            CELL_WRITE: slot_next = wr;
            CELL_TOUCH: slot_next.stamp = wr.stamp;
            default:    slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule
